// File: sv/arfc_pkg.sv
// Shared types, constants and register codes for the aligned read filter counter.
`default_nettype none
package arfc_pkg;

    localparam int CNT_W = 32;
    localparam int OUT_CNT_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W = 128;
    localparam int OUT_DATA_W = 104;
    localparam int SUM_W = 35;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REGION_START = 3'd0,
        REG_REGION_END   = 3'd1,
        REG_SHIFT_AMOUNT = 3'd2,
        REG_QUALITY_MIN  = 3'd3,
        REG_QUALITY_MAX  = 3'd4,
        REG_INSERT_MIN   = 3'd5,
        REG_INSERT_MAX   = 3'd6,
        REG_OPTIONS      = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        TAG_UNKNOWN     = 2'd0,
        TAG_REFERENCE   = 2'd1,
        TAG_ALTERNATIVE = 2'd2,
        TAG_INVALID     = 2'd3
    } tag_t;

    typedef enum logic [1:0] {
        STRAND_ANY   = 2'd0,
        STRAND_PLUS  = 2'd1,
        STRAND_MINUS = 2'd2,
        STRAND_OTHER = 2'd3
    } strand_t;

    // options register bit positions
    localparam int OPT_ENDSEL     = 2;
    localparam int OPT_HALFINSERT = 3;
    localparam int OPT_READ1      = 4;
    localparam int OPT_READ2      = 5;
    localparam int OPT_KEEPSEC    = 6;
    localparam int OPT_SPLICED    = 7;
    localparam int OPT_ALLELIC    = 8;

    // flag word bit positions
    localparam int FLG_REVERSE   = 4;
    localparam int FLG_READ1     = 6;
    localparam int FLG_READ2     = 7;
    localparam int FLG_SECONDARY = 8;

    typedef struct packed {
        logic [30:0]        region_start;
        logic [30:0]        region_end;
        logic signed [20:0] shift_amount;
        logic [7:0]         quality_min;
        logic [7:0]         quality_max;
        logic signed [31:0] insert_min;
        logic signed [31:0] insert_max;
        logic [8:0]         options;
    } cfg_t;

    // packed high to low so that restart sits in the lowest bit
    typedef struct packed {
        logic [5:0]         pad;
        logic [1:0]         allele_tag;
        logic               spliced;
        logic [30:0]        right_end;
        logic [30:0]        left_pos;
        logic signed [31:0] insert_size;
        logic [7:0]         mapq;
        logic [15:0]        flags;
        logic               restart;
    } item_t;

    typedef struct packed {
        logic                    restart;
        logic                    pass;
        logic signed [SUM_W-1:0] sum;
        logic [1:0]              tag;
    } dec_t;

    typedef struct packed {
        logic [5:0]           pad;
        logic                 tag_error;
        logic [OUT_CNT_W-1:0] alternative_count;
        logic [OUT_CNT_W-1:0] reference_count;
        logic [OUT_CNT_W-1:0] unknown_count;
        logic                 counted;
    } res_t;

endpackage
`default_nettype wire

// File: sv/arfc_filter.sv
// Filter chain and doubled anchor sum, registered into the decision stage.
`default_nettype none
module arfc_filter (
    input  wire logic            aclk,
    input  wire arfc_pkg::item_t item,
    input  wire arfc_pkg::cfg_t  cfg,
    input  wire logic            load,
    output arfc_pkg::dec_t       dec_reg
);

    arfc_pkg::dec_t        dec_next;
    logic                  rev;
    logic [31:0]           ab;
    logic                  rej_splice;
    logic                  rej_qual;
    logic                  rej_ins;
    logic                  rej_read;
    logic                  rej_sec;
    logic                  rej_strand;
    logic [15:0]           readmask;
    logic                  use_left;
    logic signed [32:0]    base;
    logic signed [arfc_pkg::SUM_W-1:0] isz_x;
    logic signed [arfc_pkg::SUM_W-1:0] sh_x;
    logic signed [arfc_pkg::SUM_W-1:0] shift2;
    logic signed [arfc_pkg::SUM_W-1:0] base2;

    always_comb begin
        rev = item.flags[arfc_pkg::FLG_REVERSE];
        ab = item.insert_size[31] ? 32'(-item.insert_size) : item.insert_size;

        rej_splice = !cfg.options[arfc_pkg::OPT_SPLICED] && item.spliced;
        rej_qual = (item.mapq < cfg.quality_min) || (item.mapq > cfg.quality_max);
        rej_ins = (!cfg.insert_min[31] && (ab < cfg.insert_min))
                  || ((cfg.insert_max != -32'sd1)
                      && (cfg.insert_max[31] || (ab > cfg.insert_max)));

        readmask = '0;
        readmask[arfc_pkg::FLG_READ1] = cfg.options[arfc_pkg::OPT_READ1];
        readmask[arfc_pkg::FLG_READ2] = cfg.options[arfc_pkg::OPT_READ2];
        rej_read = (item.flags[arfc_pkg::FLG_READ1] || item.flags[arfc_pkg::FLG_READ2])
                   && ((item.flags & readmask) == 16'd0);
        rej_sec = item.flags[arfc_pkg::FLG_SECONDARY] && !cfg.options[arfc_pkg::OPT_KEEPSEC];

        case (arfc_pkg::strand_t'(cfg.options[1:0]))
            arfc_pkg::STRAND_ANY:  rej_strand = 1'b0;
            arfc_pkg::STRAND_PLUS: rej_strand = rev;
            default:               rej_strand = !rev;
        endcase

        // half-position units
        isz_x = {{3{item.insert_size[31]}}, item.insert_size};
        sh_x = {{14{cfg.shift_amount[20]}}, cfg.shift_amount} <<< 1;
        if (cfg.options[arfc_pkg::OPT_HALFINSERT]) begin
            shift2 = (item.insert_size > 0) ? isz_x - 35'sd1 : isz_x + 35'sd1;
        end else begin
            shift2 = rev ? -sh_x : sh_x;
        end

        use_left = (rev == cfg.options[arfc_pkg::OPT_ENDSEL]);
        base = use_left ? {2'b00, item.left_pos} : {2'b00, item.right_end} - 33'sd1;
        base2 = {{2{base[32]}}, base} <<< 1;

        dec_next.restart = item.restart;
        dec_next.pass = !(rej_splice || rej_qual || rej_ins || rej_read
                          || rej_sec || rej_strand);
        dec_next.sum = base2 + shift2;
        dec_next.tag = item.allele_tag;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            dec_reg <= dec_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/arfc_counter.sv
// Region check, allele selection and saturating counters with the result register.
`default_nettype none
module arfc_counter (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire arfc_pkg::dec_t dec,
    input  wire arfc_pkg::cfg_t cfg,
    input  wire logic           load,
    output arfc_pkg::res_t      res_reg
);

    localparam logic [arfc_pkg::CNT_W-1:0] CntTop = '1;

    logic [arfc_pkg::CNT_W-1:0] unk_reg, unk_next, unk_base;
    logic [arfc_pkg::CNT_W-1:0] ref_reg, ref_next, ref_base;
    logic [arfc_pkg::CNT_W-1:0] alt_reg, alt_next, alt_base;
    logic [63:0]                unk_w, ref_w, alt_w;
    logic signed [arfc_pkg::SUM_W-1:0] pos;
    logic signed [arfc_pkg::SUM_W-1:0] rs_x;
    logic signed [arfc_pkg::SUM_W-1:0] re_x;
    logic                       hit;
    logic                       inc_unk, inc_ref, inc_alt, tag_err;
    arfc_pkg::res_t             res_next;

    always_comb begin
        // truncate toward zero
        pos = (dec.sum + $signed({{(arfc_pkg::SUM_W-1){1'b0}}, dec.sum[arfc_pkg::SUM_W-1]}))
              >>> 1;
        rs_x = {4'b0000, cfg.region_start};
        re_x = {4'b0000, cfg.region_end};
        hit = dec.pass && (pos >= rs_x) && (pos < re_x);

        inc_unk = 1'b0;
        inc_ref = 1'b0;
        inc_alt = 1'b0;
        tag_err = 1'b0;
        if (hit) begin
            if (!cfg.options[arfc_pkg::OPT_ALLELIC]) begin
                inc_unk = 1'b1;
            end else begin
                case (arfc_pkg::tag_t'(dec.tag))
                    arfc_pkg::TAG_UNKNOWN:     inc_unk = 1'b1;
                    arfc_pkg::TAG_REFERENCE:   inc_ref = 1'b1;
                    arfc_pkg::TAG_ALTERNATIVE: inc_alt = 1'b1;
                    default:                   tag_err = 1'b1;
                endcase
            end
        end

        unk_base = dec.restart ? '0 : unk_reg;
        ref_base = dec.restart ? '0 : ref_reg;
        alt_base = dec.restart ? '0 : alt_reg;
        unk_next = (inc_unk && unk_base != CntTop) ? unk_base + 1'b1 : unk_base;
        ref_next = (inc_ref && ref_base != CntTop) ? ref_base + 1'b1 : ref_base;
        alt_next = (inc_alt && alt_base != CntTop) ? alt_base + 1'b1 : alt_base;

        unk_w = 64'(unk_next);
        ref_w = 64'(ref_next);
        alt_w = 64'(alt_next);

        res_next.pad = '0;
        res_next.counted = inc_unk || inc_ref || inc_alt;
        res_next.tag_error = tag_err;
        res_next.unknown_count = unk_w[arfc_pkg::OUT_CNT_W-1:0];
        res_next.reference_count = ref_w[arfc_pkg::OUT_CNT_W-1:0];
        res_next.alternative_count = alt_w[arfc_pkg::OUT_CNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unk_reg <= '0;
            ref_reg <= '0;
            alt_reg <= '0;
        end else if (load) begin
            unk_reg <= unk_next;
            ref_reg <= ref_next;
            alt_reg <= alt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/aligned_read_filter_counter_core.sv
// Aligned-read filter and counter top level: config registers, input stage, stream control.
//
// Use: one alignment per input word on s_axis; one result word per alignment on m_axis.
// Configuration goes via cfg_wr_en/cfg_index/cfg_wdata; the user writes it only while idle,
// not enforced by the block; indices follow the register list (region_start .. options).
// Pipeline: input register, decision register (filters and doubled anchor sum),
// result register (region check and counter update). A word accepted on s_axis
// passes through the three registers to m_axis; one word per cycle is sustained
// while m_axis_tready stays high.
// Counters saturate; a word with restart set clears them before it is handled.
// Reset (aresetn low, synchronous) empties the pipeline, clears the counters and
// loads the register defaults. When m_axis_tready is low the stages fill up and
// s_axis_tready drops once all three hold a word; nothing is dropped or repeated.
`default_nettype none
module aligned_read_filter_counter_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // restart, flags, mapq, insert_size, left_pos, right_end, spliced, allele_tag
    input  wire logic [arfc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // counted, unknown_count, reference_count, alternative_count, tag_error
    output logic [arfc_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    input  wire logic                               cfg_wr_en,
    input  wire logic [arfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [arfc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    arfc_pkg::cfg_t  cfg_reg;
    arfc_pkg::item_t item_reg;
    arfc_pkg::dec_t  dec_reg;
    arfc_pkg::res_t  res_reg;
    logic            v1_reg, v2_reg, v3_reg;
    logic            rdy2, rdy3, load1, load2, load3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.region_start <= '0;
            cfg_reg.region_end <= '0;
            cfg_reg.shift_amount <= '0;
            cfg_reg.quality_min <= '0;
            cfg_reg.quality_max <= 8'd255;
            cfg_reg.insert_min <= -32'sd1;
            cfg_reg.insert_max <= -32'sd1;
            cfg_reg.options <= 9'd176;
        end else if (cfg_wr_en) begin
            case (arfc_pkg::reg_idx_t'(cfg_index))
                arfc_pkg::REG_REGION_START: cfg_reg.region_start <= cfg_wdata[30:0];
                arfc_pkg::REG_REGION_END:   cfg_reg.region_end <= cfg_wdata[30:0];
                arfc_pkg::REG_SHIFT_AMOUNT: cfg_reg.shift_amount <= cfg_wdata[20:0];
                arfc_pkg::REG_QUALITY_MIN:  cfg_reg.quality_min <= cfg_wdata[7:0];
                arfc_pkg::REG_QUALITY_MAX:  cfg_reg.quality_max <= cfg_wdata[7:0];
                arfc_pkg::REG_INSERT_MIN:   cfg_reg.insert_min <= cfg_wdata[31:0];
                arfc_pkg::REG_INSERT_MAX:   cfg_reg.insert_max <= cfg_wdata[31:0];
                arfc_pkg::REG_OPTIONS:      cfg_reg.options <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    assign rdy3 = !v3_reg || m_axis_tready;
    assign load3 = v2_reg && rdy3;
    assign rdy2 = !v2_reg || rdy3;
    assign load2 = v1_reg && rdy2;
    assign s_axis_tready = !v1_reg || rdy2;
    assign load1 = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                v1_reg <= s_axis_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load1) begin
            item_reg <= arfc_pkg::item_t'(s_axis_tdata);
        end
    end

    arfc_filter u_filter (
        .aclk    (aclk),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .load    (load2),
        .dec_reg (dec_reg)
    );

    arfc_counter u_counter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .dec     (dec_reg),
        .cfg     (cfg_reg),
        .load    (load3),
        .res_reg (res_reg)
    );

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata = res_reg;

endmodule
`default_nettype wire
